// ----- rtl/rbp_pkg.sv -----
package rbp_pkg;

  // Default sizes of the two stores.
  localparam int unsigned MAX_COLUMNS_DEF   = 512;
  localparam int unsigned MAX_ROW_BYTES_DEF = 64;

  // Widths of the effective settings, wide enough for the whole parameter range.
  localparam int unsigned COL_W = 13;  // up to 4096 columns
  localparam int unsigned NB_W  = 10;  // up to 512 bytes per row

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES    = 2'd1;

  // Item operation codes.
  localparam logic [1:0] OP_LOAD_ORDER = 2'd0;
  localparam logic [1:0] OP_WRITE_ROW  = 2'd1;
  localparam logic [1:0] OP_READ_BYTE  = 2'd2;

  // Effective, already clamped settings handed to the sequencer.
  typedef struct packed {
    logic [COL_W-1:0] cols;
    logic [NB_W-1:0]  nbytes;
  } cfg_t;

endpackage

// ----- rtl/rbp_if.sv -----
interface rbp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [8:0] index;
  logic [8:0] order_value;
  logic [7:0] row_byte;

  modport source (output valid, output op, output index, output order_value,
                  output row_byte, input ready);
  modport sink   (input valid, input op, input index, input order_value,
                  input row_byte, output ready);
endinterface

interface rbp_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] out_index;
  logic [7:0] out_byte;
  logic       bad_order;

  modport source (output valid, output out_index, output out_byte, output bad_order,
                  input ready);
  modport sink   (input valid, input out_index, input out_byte, input bad_order,
                  output ready);
endinterface

interface rbp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rbp_pkg::CFG_IDX_W-1:0]    index;
  logic [rbp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rbp_ram.sv -----
module rbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/rbp_cfg.sv -----
module rbp_cfg #(
  parameter int unsigned MAX_COLUMNS   = rbp_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROW_BYTES = rbp_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rbp_cfg_if.sink       cfg_i,
  output rbp_pkg::cfg_t cfg_o
);

  localparam logic [rbp_pkg::COL_W-1:0] ColMax   = rbp_pkg::COL_W'(MAX_COLUMNS);
  localparam logic [rbp_pkg::NB_W-1:0]  BytesMax = rbp_pkg::NB_W'(MAX_ROW_BYTES);
  localparam logic [rbp_pkg::NB_W-1:0]  BytesRst =
      (MAX_ROW_BYTES < 64) ? rbp_pkg::NB_W'(MAX_ROW_BYTES) : rbp_pkg::NB_W'(64);

  logic [rbp_pkg::COL_W-1:0] cols_q, cols_d;
  logic [rbp_pkg::NB_W-1:0]  nbytes_q, nbytes_d;
  logic [rbp_pkg::COL_W-1:0] col_wr;
  logic [rbp_pkg::NB_W-1:0]  rb_wr;

  assign cfg_i.ready = 1'b1;

  // Registers are kept in clamped form so the sequencer compares directly.
  always_comb begin
    col_wr   = {3'b000, cfg_i.data[9:0]};
    rb_wr    = {3'b000, cfg_i.data[6:0]};
    cols_d   = cols_q;
    nbytes_d = nbytes_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rbp_pkg::REG_COLUMN_COUNT: begin
          cols_d = (col_wr > ColMax) ? ColMax : col_wr;
        end
        rbp_pkg::REG_ROW_BYTES: begin
          if (rb_wr == '0) begin
            nbytes_d = rbp_pkg::NB_W'(1);
          end else if (rb_wr > BytesMax) begin
            nbytes_d = BytesMax;
          end else begin
            nbytes_d = rb_wr;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= '0;
      nbytes_q <= BytesRst;
    end else begin
      cols_q   <= cols_d;
      nbytes_q <= nbytes_d;
    end
  end

  assign cfg_o.cols   = cols_q;
  assign cfg_o.nbytes = nbytes_q;

endmodule

// ----- rtl/rbp_ctrl.sv -----
module rbp_ctrl #(
  parameter int unsigned MAX_COLUMNS   = rbp_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROW_BYTES = rbp_pkg::MAX_ROW_BYTES_DEF,
  localparam int unsigned OAW = $clog2(MAX_COLUMNS),
  localparam int unsigned RAW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rbp_pkg::cfg_t cfg_i,
  rbp_in_if.sink        in_i,
  rbp_out_if.source     out_o,
  output logic          ord_we_o,
  output logic          ord_re_o,
  output logic [OAW-1:0] ord_addr_o,
  output logic [8:0]    ord_wdata_o,
  input  logic [8:0]    ord_rdata_i,
  output logic          row_we_o,
  output logic          row_re_o,
  output logic [RAW-1:0] row_addr_o,
  output logic [7:0]    row_wdata_o,
  input  logic [7:0]    row_rdata_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam logic [rbp_pkg::COL_W-1:0] ColMax = rbp_pkg::COL_W'(MAX_COLUMNS);

  logic [0:0] state_q;
  logic [8:0] idx_q;
  logic [3:0] k_q;
  logic       ord_vld_q, bit_vld_q, base_vld_q;
  logic       bit_bad_q;
  logic [2:0] bit_sel_q;
  logic [7:0] acc_q;
  logic       bad_q;
  logic       out_valid_q;
  logic [5:0] out_index_q;
  logic [7:0] out_byte_q;
  logic       out_bad_q;

  logic        in_acc, run;
  logic        idx_row_ok, idx_ord_ok, start_rd;
  logic [11:0] iss_col;
  logic        iss_ok;
  logic        pos_bad;
  logic        finish, load_out;
  logic [OAW+11:0] ord_col_ext;
  logic [OAW+8:0]  ord_idx_ext;
  logic [RAW+8:0]  row_idx_ext;
  logic [RAW+5:0]  row_pos_ext;

  assign run         = (state_q == ST_RUN);
  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;

  assign idx_row_ok  = {1'b0, in_i.index} < cfg_i.nbytes;
  assign idx_ord_ok  = {4'b0000, in_i.index} < ColMax;
  assign start_rd    = in_acc && (in_i.op == rbp_pkg::OP_READ_BYTE) && idx_row_ok;

  // Column whose order entry is fetched next; valid columns form a prefix.
  assign iss_col = run ? {idx_q, k_q[2:0]} : {in_i.index, 3'b000};
  assign iss_ok  = run ? (!k_q[3] && ({1'b0, iss_col} < cfg_i.cols))
                       : (start_rd && ({1'b0, iss_col} < cfg_i.cols));

  // A source position at or beyond the row length reads as zero.
  assign pos_bad = !({4'b0000, ord_rdata_i} < {cfg_i.nbytes, 3'b000});

  // Order table port: loads while idle, fetches while a byte is built.
  assign ord_col_ext = {OAW'(0), iss_col};
  assign ord_idx_ext = {OAW'(0), in_i.index};
  assign ord_we_o    = in_acc && (in_i.op == rbp_pkg::OP_LOAD_ORDER) && idx_ord_ok;
  assign ord_re_o    = iss_ok;
  assign ord_addr_o  = ord_we_o ? ord_idx_ext[OAW-1:0] : ord_col_ext[OAW-1:0];
  assign ord_wdata_o = in_i.order_value;

  // Row store port: write or base read while idle, bit fetches while running.
  assign row_idx_ext = {RAW'(0), in_i.index};
  assign row_pos_ext = {RAW'(0), ord_rdata_i[8:3]};
  assign row_we_o    = in_acc && (in_i.op == rbp_pkg::OP_WRITE_ROW) && idx_row_ok;
  assign row_re_o    = start_rd || (run && ord_vld_q && !pos_bad);
  assign row_addr_o  = run ? row_pos_ext[RAW-1:0] : row_idx_ext[RAW-1:0];
  assign row_wdata_o = in_i.row_byte;

  assign finish   = run && !base_vld_q && !ord_vld_q && !bit_vld_q && !iss_ok;
  assign load_out = finish && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      ord_vld_q   <= 1'b0;
      bit_vld_q   <= 1'b0;
      base_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ord_vld_q  <= iss_ok;
      bit_vld_q  <= run && ord_vld_q;
      base_vld_q <= start_rd;
      if (start_rd) begin
        state_q <= ST_RUN;
        k_q     <= {3'b000, iss_ok};
      end else if (run) begin
        k_q <= k_q + {3'b000, iss_ok};
        if (load_out) begin
          state_q <= ST_IDLE;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_rd) begin
      idx_q <= in_i.index;
      bad_q <= 1'b0;
    end
    bit_bad_q <= pos_bad;
    bit_sel_q <= ~ord_rdata_i[2:0];
    if (base_vld_q) begin
      acc_q <= row_rdata_i;
    end else if (bit_vld_q) begin
      acc_q <= {acc_q[6:0], bit_bad_q ? 1'b0 : row_rdata_i[bit_sel_q]};
      bad_q <= bad_q | bit_bad_q;
    end
    if (load_out) begin
      out_index_q <= idx_q[5:0];
      out_byte_q  <= acc_q;
      out_bad_q   <= bad_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_index = out_index_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.bad_order = out_bad_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !(base_vld_q || ord_vld_q || bit_vld_q))
    else $error("sequencer idle with fetches in flight");

  a_base_bit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(base_vld_q && bit_vld_q))
    else $error("base byte and row bit returned together");

  a_col_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 4'd8)
    else $error("column counter passed one byte");

  a_bit_follows_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_vld_q |-> $past(ord_vld_q))
    else $error("row bit returned without an order entry");

  a_row_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(row_we_o && row_re_o))
    else $error("row store read and written in one cycle");

endmodule

// ----- rtl/row_bit_permuter.sv -----
// Row bit permuter: builds permuted row bytes from a stored order table.
//
// Channels: cfg_i writes column_count (index 0) and row_bytes (index 1); it is
// always ready. The user must write it only while the block is idle; the block
// itself does not enforce this. in_i takes one item per operation: load an
// order entry, write a row byte, or read a permuted byte. out_o returns one
// item for every read whose byte index lies inside the row; loads, writes and
// out-of-range reads return nothing. Loads and writes complete on acceptance.
// A read fetches the base byte and the order entries of those of its columns
// that lie below the column count, one entry per cycle on the single port of
// the order table; the row-bit fetch on the row store's single port follows
// each entry in the cycle after. The result register is loaded once all bits
// are gathered, and only then is the next item accepted.
// A new item is accepted as soon as the sequencer is idle, even while the
// previous result still waits in the output register. If the receiver stalls
// and a second result is ready, the sequencer holds it until the register
// frees. Reset clears the sequencer, the output valid flag and the settings
// (column_count 0, row_bytes min(64, MAX_ROW_BYTES)); memories are not reset.
module row_bit_permuter #(
  parameter int unsigned MAX_COLUMNS   = rbp_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROW_BYTES = rbp_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbp_cfg_if.sink   cfg_i,
  rbp_in_if.sink    in_i,
  rbp_out_if.source out_o
);

  localparam int unsigned OAW = $clog2(MAX_COLUMNS);
  localparam int unsigned RAW = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;

  rbp_pkg::cfg_t  cfg;

  // Order table port.
  logic           ord_we, ord_re;
  logic [OAW-1:0] ord_addr;
  logic [8:0]     ord_wdata, ord_rdata;

  // Row store port.
  logic           row_we, row_re;
  logic [RAW-1:0] row_addr;
  logic [7:0]     row_wdata, row_rdata;

  // Settings are clamped on write so the sequencer never sees out-of-range values.
  rbp_cfg #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // The order table holds one source bit position per output column.
  rbp_ram #(
    .WIDTH (9),
    .DEPTH (MAX_COLUMNS)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .re_i    (ord_re),
    .addr_i  (ord_addr),
    .wdata_i (ord_wdata),
    .rdata_o (ord_rdata)
  );

  // The row store holds the original bytes of the current row.
  rbp_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .re_i    (row_re),
    .addr_i  (row_addr),
    .wdata_i (row_wdata),
    .rdata_o (row_rdata)
  );

  // The sequencer overlaps the fetch of the next order entry with the row-bit
  // fetch of the current one. Only one item is in work at a time and the row
  // store is never written during a read, so no forwarding is needed.
  rbp_ctrl #(
    .MAX_COLUMNS   (MAX_COLUMNS),
    .MAX_ROW_BYTES (MAX_ROW_BYTES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_o       (out_o),
    .ord_we_o    (ord_we),
    .ord_re_o    (ord_re),
    .ord_addr_o  (ord_addr),
    .ord_wdata_o (ord_wdata),
    .ord_rdata_i (ord_rdata),
    .row_we_o    (row_we),
    .row_re_o    (row_re),
    .row_addr_o  (row_addr),
    .row_wdata_o (row_wdata),
    .row_rdata_i (row_rdata)
  );

endmodule
